### hw/rtl/base64_stream_decoder_assert.svh
// Assertion macros used by the checker of the base64 stream decoder.
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define B64SD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("base64 stream decoder check failed");

// Next-cycle implication, switched off while reset is high.
`define B64SD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("base64 stream decoder check failed");

// Same-cycle implication that also holds across reset.
`define B64SD_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("base64 stream decoder check failed");

`endif

### hw/rtl/b64sd_pkg.sv
package b64sd_pkg;

   // Field widths of the request and response channels
   localparam int CHAR_W = 8;
   localparam int BYTE_W = 8;
   localparam int CNT_W  = 13;
   localparam int ACC_W  = 14;
   localparam int PEND_W = 4;
   localparam int SEXT_W = 6;

   // Hard ceiling on decoded bytes per string
   localparam int MAX_CAPACITY = 4096;
   localparam logic [CNT_W-1:0] CAPACITY_RESET = CNT_W'(4096);

   // Character codes with special meaning
   localparam logic [CHAR_W-1:0] CHAR_END = 8'd0;
   localparam logic [CHAR_W-1:0] CHAR_LF  = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_CR  = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_PAD = 8'd61;

   // Response status codes
   typedef enum logic [1:0] {
      ST_DATA    = 2'd0,
      ST_OK      = 2'd1,
      ST_BADCHAR = 2'd2,
      ST_OVERCAP = 2'd3
   } status_type;

   // Input stage contents
   typedef struct packed {
      logic              valid;
      logic [CHAR_W-1:0] char_code;
   } stage_type;

   // One response item
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      status_type        status;
      logic [CNT_W-1:0]  byte_count;
      logic              final_flag;
   } rsp_type;

   // Response push from the decode core to the output buffer
   typedef struct packed {
      logic    push;
      rsp_type rsp;
   } push_type;

   // Mapped symbol: valid flag and 6-bit value
   typedef struct packed {
      logic              valid;
      logic [SEXT_W-1:0] value;
   } sextet_type;

   // Map a base64 symbol to its 6-bit value
   function automatic sextet_type sextet_of(input logic [CHAR_W-1:0] ch);
      sextet_type s;
      logic [CHAR_W-1:0] d;
      s.valid = 1'b1;
      s.value = '0;
      d       = '0;
      if (ch >= 8'd65 && ch <= 8'd90) begin
         d       = ch - 8'd65;
         s.value = d[SEXT_W-1:0];
      end else if (ch >= 8'd97 && ch <= 8'd122) begin
         d       = ch - 8'd97 + 8'd26;
         s.value = d[SEXT_W-1:0];
      end else if (ch >= 8'd48 && ch <= 8'd57) begin
         d       = ch - 8'd48 + 8'd52;
         s.value = d[SEXT_W-1:0];
      end else if (ch == 8'd43) begin
         s.value = 6'd62;
      end else if (ch == 8'd47) begin
         s.value = 6'd63;
      end else begin
         s.valid = 1'b0;
      end
      return s;
   endfunction

endpackage

### hw/rtl/b64sd_in_stage.sv
module b64sd_in_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [b64sd_pkg::CHAR_W-1:0]  req_char_code,
   input  logic                          out_full,
   output b64sd_pkg::stage_type          stage,
   output logic                          fire
);
   import b64sd_pkg::*;

   logic      valid_ff, valid_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic      load;

   // Advance the held request whenever the output buffer has room
   assign fire      = valid_ff && !out_full;
   assign load      = !valid_ff || fire;
   assign req_stall = valid_ff && out_full;

   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      if (load) begin
         valid_in = req_valid;
         char_in  = req_char_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      char_ff <= char_in;
   end

   assign stage.valid     = valid_ff;
   assign stage.char_code = char_ff;

endmodule

### hw/rtl/b64sd_core.sv
module b64sd_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [b64sd_pkg::CNT_W-1:0]  csr_write_data,
   input  b64sd_pkg::stage_type         stage,
   input  logic                         fire,
   output b64sd_pkg::push_type          push
);
   import b64sd_pkg::*;

   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   status_type        err_ff, err_in;

   logic              is_end, is_skip, has_err, full;
   sextet_type        sx;
   logic [ACC_W-1:0]  acc_next, acc_shift;
   logic [PEND_W-1:0] pend_sum, pend_left;
   logic [CNT_W-1:0]  limit, count_inc;

   // Hold the capacity register; a write reaches the limit once it is registered
   assign cap_in = csr_write_enable ? csr_write_data : cap_ff;

   // Effective limit is the smaller of the register and the ceiling
   assign limit = (int'(cap_ff) > MAX_CAPACITY) ? CNT_W'(MAX_CAPACITY) : cap_ff;

   // Classify the held character and build the shifted accumulator
   assign is_end    = stage.char_code == CHAR_END;
   assign is_skip   = stage.char_code == CHAR_PAD || stage.char_code == CHAR_CR ||
                      stage.char_code == CHAR_LF;
   assign has_err   = err_ff != ST_DATA;
   assign sx        = sextet_of(stage.char_code);
   assign acc_next  = {acc_ff[ACC_W-SEXT_W-1:0], sx.value};
   assign pend_sum  = pend_ff + PEND_W'(6);
   assign full      = pend_sum >= PEND_W'(8);
   assign pend_left = pend_sum - PEND_W'(8);
   assign acc_shift = acc_next >> pend_left;
   assign count_inc = count_ff + CNT_W'(1);

   // Decode one request into next state and at most one response
   always_comb begin
      acc_in   = acc_ff;
      pend_in  = pend_ff;
      count_in = count_ff;
      err_in   = err_ff;
      push     = '0;
      push.rsp.status = ST_DATA;
      if (fire) begin
         if (is_end) begin
            push.push            = 1'b1;
            push.rsp.final_flag  = 1'b1;
            if (has_err) begin
               push.rsp.status     = err_ff;
            end else begin
               push.rsp.status     = ST_OK;
               push.rsp.byte_count = count_ff;
            end
            acc_in   = '0;
            pend_in  = '0;
            count_in = '0;
            err_in   = ST_DATA;
         end else if (!is_skip && !has_err) begin
            if (!sx.valid) begin
               err_in = ST_BADCHAR;
            end else begin
               acc_in  = acc_next;
               pend_in = full ? pend_left : pend_sum;
               if (full) begin
                  if (count_ff >= limit) begin
                     err_in = ST_OVERCAP;
                  end else begin
                     count_in            = count_inc;
                     push.push           = 1'b1;
                     push.rsp.out_byte   = acc_shift[BYTE_W-1:0];
                     push.rsp.byte_count = count_inc;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAPACITY_RESET;
         acc_ff   <= '0;
         pend_ff  <= '0;
         count_ff <= '0;
         err_ff   <= ST_DATA;
      end else begin
         cap_ff   <= cap_in;
         acc_ff   <= acc_in;
         pend_ff  <= pend_in;
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end

endmodule

### hw/rtl/b64sd_out_buf.sv
module b64sd_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  b64sd_pkg::push_type   push,
   output logic                  out_full,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output b64sd_pkg::rsp_type    rsp
);
   import b64sd_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign pop      = main_valid_ff && !rsp_stall;
   assign out_full = skid_valid_ff;

   // Refill the output register from the skid stage first, then from the core
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = push.push;
            skid_in       = push.rsp;
         end else begin
            main_valid_in = push.push;
            main_in       = push.rsp;
         end
      end else if (push.push) begin
         skid_valid_in = 1'b1;
         skid_in       = push.rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = main_valid_ff;
   assign rsp       = main_ff;

endmodule

### hw/rtl/base64_stream_decoder.sv
// Streaming base64 decoder: one character per request, one request per cycle
// unless req_stall is high. Each request passes an input register, a single
// decode step and a two-entry output buffer: the request is held in the input
// register and its response then in the output buffer, whose head drives the ports;
// the sustained rate is one character per cycle, limited only by response
// stalls. A data response carries each completed byte, and a zero
// character closes the string with one final status response (done with the
// byte count, invalid character, or over capacity); '=', CR and LF are
// skipped. After an error status the bytes already sent for that string are
// to be discarded. csr_write_data sets the byte limit per string, capped at
// 4096; it resets to 4096 and should be written only while the block is idle.
module base64_stream_decoder (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [b64sd_pkg::CNT_W-1:0]  csr_write_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [b64sd_pkg::CHAR_W-1:0] req_char_code,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [b64sd_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic [1:0]                   rsp_status,
   output logic [b64sd_pkg::CNT_W-1:0]  rsp_byte_count,
   output logic                         rsp_final_flag
);
   import b64sd_pkg::*;

   stage_type stage;
   push_type  push;
   rsp_type   rsp;
   logic      fire;
   logic      out_full;

   b64sd_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .out_full      (out_full),
      .stage         (stage),
      .fire          (fire)
   );

   b64sd_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .stage            (stage),
      .fire             (fire),
      .push             (push)
   );

   b64sd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_full  (out_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   // Unpack the response onto separate ports
   assign rsp_out_byte   = rsp.out_byte;
   assign rsp_status     = rsp.status;
   assign rsp_byte_count = rsp.byte_count;
   assign rsp_final_flag = rsp.final_flag;

endmodule

### hw/rtl/b64sd_checker.sv
module b64sd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [b64sd_pkg::BYTE_W-1:0] rsp_out_byte,
   input logic [1:0]                   rsp_status,
   input logic [b64sd_pkg::CNT_W-1:0]  rsp_byte_count,
   input logic                         rsp_final_flag
);
   import b64sd_pkg::*;

`include "base64_stream_decoder_assert.svh"

   // A stalled response holds its payload
   `B64SD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_out_byte) && $stable(rsp_status) &&
      $stable(rsp_byte_count) && $stable(rsp_final_flag))

   // Reset empties the output buffer
   `B64SD_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset), !rsp_valid)

   // Request back-pressure only follows a stalled response
   `B64SD_ASSERT_IMPLY(a_stall_cause, clock, reset, req_stall,
      $past(rsp_valid && rsp_stall))

   // Data responses count from one and never close the string
   `B64SD_ASSERT_IMPLY(a_data_shape, clock, reset, rsp_valid && rsp_status == ST_DATA,
      !rsp_final_flag && rsp_byte_count != '0)

endmodule

bind base64_stream_decoder b64sd_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_status     (rsp_status),
   .rsp_byte_count (rsp_byte_count),
   .rsp_final_flag (rsp_final_flag)
);
